>>> design/trtd_pkg.sv
// Package for the triangle tile rasterizer with depth test.
// Holds the item types, the divider request and response types and shared codes.
// No dependencies.
package trtd_pkg;

    localparam int MAX_DIM_DEF   = 512;
    localparam int TILE_SIZE_DEF = 8;

    // Shared divider: numerator and denominator widths.
    localparam int DIV_NW = 58;
    localparam int DIV_DW = 42;

    localparam logic [23:0] DEPTH_MAX  = 24'hFFFFFF;
    localparam logic [16:0] WEIGHT_ONE = 17'h10000;

    // Command codes.
    localparam logic CMD_CLEAR  = 1'b0;
    localparam logic CMD_RASTER = 1'b1;

    // Configuration register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] vert0_x;
        logic signed [15:0] vert0_y;
        logic [23:0]        vert0_w;
        logic signed [15:0] vert1_x;
        logic signed [15:0] vert1_y;
        logic [23:0]        vert1_w;
        logic signed [15:0] vert2_x;
        logic signed [15:0] vert2_y;
        logic [23:0]        vert2_w;
        logic [5:0]         tile_col;
        logic [5:0]         tile_row;
    } trtd_in_t;

    typedef struct packed {
        logic [8:0]  pixel_x;
        logic [8:0]  pixel_y;
        logic [23:0] depth;
        logic [16:0] weight0;
        logic [16:0] weight1;
        logic [16:0] weight2;
        logic        last_fragment;
    } trtd_out_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } trtd_div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } trtd_div_rsp_t;

endpackage

>>> design/trtd_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on trtd_pkg for widths and the request and response types.
module trtd_div import trtd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  trtd_div_req_t req,
    output trtd_div_rsp_t rsp
);

    localparam int CNTW = $clog2(DIV_NW);
    localparam logic [CNTW-1:0] LAST_CNT = CNTW'(DIV_NW - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_NW-1:0] quo_reg;

    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              fits;
    logic [DIV_DW-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_NW-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                den_reg  <= req.den;
                quo_reg  <= req.num;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DIV_NW-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    // A new division never starts on top of one in flight.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    // Completion is flagged only once the unit has stopped iterating.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule

>>> design/trtd_mem.sv
// Frame depth store: one write and one registered read per cycle.
// Depends on trtd_pkg for the default depth, MAX_DIM_DEF squared.
module trtd_mem import trtd_pkg::*;
#(
    parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [23:0]              wdata,
    output logic [23:0]              rdata
);

    logic [23:0] store_mem [0:DEPTH-1];
    logic [23:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= store_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/triangle_tile_raster_depth_test_top.sv
// Triangle tile rasterizer with depth test: sequencer, edge multiplier and output stage.
// Depends on trtd_pkg, trtd_div (shared divider) and trtd_mem (depth store).
//
//   Channel   Handshake              Payload      Direction
//   in        in_valid / in_stall    in_data      triangle or clear item into the block
//   out       out_valid / out_stall  out_data     fragments of raster items out of the block
//   cfg       cfg_valid / cfg_ready  cfg_index,   frame_width and frame_height writes
//                                    cfg_data
//
// A clear item sweeps the whole depth store at one entry per cycle.
// After reset the same sweep runs and no item is taken while it runs.
// A raster item is accepted, its box set up and, at the end, the held fragment flushed;
// per pixel of the clipped box the edge products, address and coverage check follow. A
// covered pixel adds up to ten divides, each issued, iterated and returned, then the
// store read, the compare and, for a passing fragment, the emit.
// Each fragment is held back one step so that the last one can carry last_fragment;
// a stalled output only blocks the sequencer when the held fragment must be pushed out, by the next one or at flush.
module triangle_tile_raster_depth_test_top import trtd_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int TILE_SIZE = TILE_SIZE_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  trtd_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output trtd_out_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_index,
    input  logic [9:0] cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = 14;
    localparam int EW    = 38;
    localparam logic [AW-1:0]        LAST_ADDR = AW'(DEPTH - 1);
    localparam logic signed [CW-1:0] DIM_C     = CW'(MAX_DIM);
    localparam logic signed [CW-1:0] TILE_C    = CW'(TILE_SIZE);
    localparam logic signed [CW-1:0] ONE_C     = CW'(1);

    // Steps of the division sequence for one covered pixel.
    localparam logic [3:0] DOP_L0 = 4'd0;
    localparam logic [3:0] DOP_L1 = 4'd1;
    localparam logic [3:0] DOP_L2 = 4'd2;
    localparam logic [3:0] DOP_A0 = 4'd3;
    localparam logic [3:0] DOP_A1 = 4'd4;
    localparam logic [3:0] DOP_A2 = 4'd5;
    localparam logic [3:0] DOP_Z  = 4'd6;
    localparam logic [3:0] DOP_W0 = 4'd7;
    localparam logic [3:0] DOP_W1 = 4'd8;
    localparam logic [3:0] DOP_W2 = 4'd9;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BOX,
        ST_MUL,
        ST_CHK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MEM_RD,
        ST_MEM_CMP,
        ST_EMIT,
        ST_NEXT,
        ST_FLUSH
    } state_t;

    state_t                 state_reg;
    trtd_in_t               in_reg;
    logic [9:0]             fw_reg;
    logic [9:0]             fh_reg;
    logic signed [CW-1:0]   minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic signed [CW-1:0]   x_reg, y_reg;
    logic [2:0]             mcnt_reg;
    logic signed [35:0]     prod_reg;
    logic signed [EW-1:0]   e_reg [3];
    logic [AW-1:0]          addr_reg;
    logic [3:0]             dop_reg;
    logic [16:0]            l_reg [3];
    logic [40:0]            a_reg [3];
    logic [23:0]            z_reg;
    logic [16:0]            wt_reg [3];
    trtd_out_t              hold_reg;
    logic                   hold_vld_reg;
    trtd_out_t              out_reg;
    logic                   out_vld_reg;

    logic signed [15:0]     vx [3];
    logic signed [15:0]     vy [3];
    logic [23:0]            vw [3];
    logic signed [CW-1:0]   fx [3];
    logic signed [CW-1:0]   fy [3];
    logic signed [CW-1:0]   bmin_x, bmax_x, bmin_y, bmax_y;
    logic signed [CW-1:0]   fw_c, fh_c, tx0, ty0;
    logic signed [CW-1:0]   bx_lo, bx_hi, by_lo, by_hi;
    logic                   box_empty;
    logic signed [17:0]     px, py;
    logic signed [17:0]     dx [3];
    logic signed [17:0]     dy [3];
    logic signed [17:0]     ma, mb;
    logic signed [35:0]     prod;
    logic                   any_neg;
    logic [39:0]            s_sum;
    logic [41:0]            asum;
    logic                   asum_zero;
    trtd_div_req_t          div_req;
    trtd_div_rsp_t          div_rsp;
    logic                   mem_re, mem_we;
    logic [23:0]            mem_wdata, mem_rdata;
    logic                   depth_pass;
    logic                   out_free;
    logic                   out_load;
    logic                   in_fire;
    trtd_out_t              frag;
    trtd_out_t              last_frag;

    function automatic logic signed [CW-1:0] smin(logic signed [CW-1:0] a,
                                                  logic signed [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [CW-1:0] smax(logic signed [CW-1:0] a,
                                                  logic signed [CW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Vertex fields, with a w of zero taken as a w of one.
    always_comb
    begin
        vx[0] = in_reg.vert0_x;
        vy[0] = in_reg.vert0_y;
        vw[0] = (in_reg.vert0_w == '0) ? 24'd1 : in_reg.vert0_w;
        vx[1] = in_reg.vert1_x;
        vy[1] = in_reg.vert1_y;
        vw[1] = (in_reg.vert1_w == '0) ? 24'd1 : in_reg.vert1_w;
        vx[2] = in_reg.vert2_x;
        vy[2] = in_reg.vert2_y;
        vw[2] = (in_reg.vert2_w == '0) ? 24'd1 : in_reg.vert2_w;
        for (int i = 0; i < 3; i++)
        begin
            fx[i] = CW'(vx[i] >>> 4);
            fy[i] = CW'(vy[i] >>> 4);
        end
    end

    // Bounding box in whole pixels, clipped to the screen and to the tile.
    // The tile origin is never negative, so it also covers the clip at zero.
    always_comb
    begin
        bmin_x = smin(smin(fx[0], fx[1]), fx[2]);
        bmax_x = smax(smax(fx[0], fx[1]), fx[2]);
        bmin_y = smin(smin(fy[0], fy[1]), fy[2]);
        bmax_y = smax(smax(fy[0], fy[1]), fy[2]);
        fw_c   = ($signed(CW'(fw_reg)) > DIM_C) ? DIM_C : $signed(CW'(fw_reg));
        fh_c   = ($signed(CW'(fh_reg)) > DIM_C) ? DIM_C : $signed(CW'(fh_reg));
        tx0    = $signed(CW'(in_reg.tile_col)) * TILE_C;
        ty0    = $signed(CW'(in_reg.tile_row)) * TILE_C;
        bx_lo  = smax(bmin_x, tx0);
        by_lo  = smax(bmin_y, ty0);
        bx_hi  = smin(smin(bmax_x, fw_c - ONE_C), tx0 + TILE_C - ONE_C);
        by_hi  = smin(smin(bmax_y, fh_c - ONE_C), ty0 + TILE_C - ONE_C);
        box_empty = (bx_lo > bx_hi) || (by_lo > by_hi);
    end

    // Operand select for the shared edge multiplier. Products come in pairs, one
    // pair per edge value facing each vertex, and the last product is the row offset.
    always_comb
    begin
        px = 18'(x_reg) <<< 4;
        py = 18'(y_reg) <<< 4;
        for (int i = 0; i < 3; i++)
        begin
            dx[i] = 18'(vx[i]) - px;
            dy[i] = 18'(vy[i]) - py;
        end
        case (mcnt_reg)
            3'd0:    begin ma = dx[1]; mb = dy[2]; end
            3'd1:    begin ma = dy[1]; mb = dx[2]; end
            3'd2:    begin ma = dx[2]; mb = dy[0]; end
            3'd3:    begin ma = dy[2]; mb = dx[0]; end
            3'd4:    begin ma = dx[0]; mb = dy[1]; end
            3'd5:    begin ma = dy[0]; mb = dx[1]; end
            default: begin ma = 18'(y_reg); mb = 18'(fw_c); end
        endcase
        prod = ma * mb;
    end

    always_comb
    begin
        any_neg   = e_reg[0][EW-1] | e_reg[1][EW-1] | e_reg[2][EW-1];
        s_sum     = 40'($unsigned(e_reg[0])) + 40'($unsigned(e_reg[1]))
                  + 40'($unsigned(e_reg[2]));
        asum      = 42'(a_reg[0]) + 42'(a_reg[1]) + 42'(a_reg[2]);
        asum_zero = (asum == '0);
    end

    // Division requests: barycentric weights, their division by w, depth, final weights.
    always_comb
    begin
        div_req.start = (state_reg == ST_DIV_GO) && !((dop_reg == DOP_Z) && asum_zero);
        div_req.num   = '0;
        div_req.den   = 42'(asum);
        case (dop_reg)
            DOP_L0:  begin div_req.num = DIV_NW'($unsigned(e_reg[0])) << 16;
                           div_req.den = 42'(s_sum); end
            DOP_L1:  begin div_req.num = DIV_NW'($unsigned(e_reg[1])) << 16;
                           div_req.den = 42'(s_sum); end
            DOP_L2:  begin div_req.num = DIV_NW'($unsigned(e_reg[2])) << 16;
                           div_req.den = 42'(s_sum); end
            DOP_A0:  begin div_req.num = DIV_NW'(l_reg[0]) << 24; div_req.den = 42'(vw[0]); end
            DOP_A1:  begin div_req.num = DIV_NW'(l_reg[1]) << 24; div_req.den = 42'(vw[1]); end
            DOP_A2:  begin div_req.num = DIV_NW'(l_reg[2]) << 24; div_req.den = 42'(vw[2]); end
            DOP_Z:   div_req.num = DIV_NW'(1) << 40;
            DOP_W0:  div_req.num = DIV_NW'(a_reg[0]) << 16;
            DOP_W1:  div_req.num = DIV_NW'(a_reg[1]) << 16;
            DOP_W2:  div_req.num = DIV_NW'(a_reg[2]) << 16;
            default: div_req.num = '0;
        endcase
    end

    trtd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // The depth store is written by the clearing sweep and by passing fragments.
    always_comb
    begin
        depth_pass = (z_reg <= mem_rdata);
        mem_re     = (state_reg == ST_MEM_RD);
        mem_we     = (state_reg == ST_CLEAR) || ((state_reg == ST_MEM_CMP) && depth_pass);
        mem_wdata  = (state_reg == ST_CLEAR) ? DEPTH_MAX : z_reg;
    end

    trtd_mem #(.DEPTH(DEPTH)) u_mem
    (
        .clk   (clk),
        .rd_en (mem_re),
        .wr_en (mem_we),
        .addr  (addr_reg),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        frag.pixel_x       = x_reg[8:0];
        frag.pixel_y       = y_reg[8:0];
        frag.depth         = z_reg;
        frag.weight0       = wt_reg[0];
        frag.weight1       = wt_reg[1];
        frag.weight2       = wt_reg[2];
        frag.last_fragment = 1'b0;
        last_frag               = hold_reg;
        last_frag.last_fragment = 1'b1;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_vld_reg || !out_stall;
    // The held fragment moves to the output register when a new one pushes it or at flush.
    assign out_load  = out_free && hold_vld_reg
                       && ((state_reg == ST_EMIT) || (state_reg == ST_FLUSH));
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            fw_reg       <= 10'd512;
            fh_reg       <= 10'd512;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            mcnt_reg     <= '0;
            dop_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  fw_reg <= cfg_data;
                    REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                    default:          fw_reg <= fw_reg;
                endcase
            end

            // The output register drains independently of the sequencer.
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == LAST_ADDR)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        in_reg <= in_data;
                        if (in_data.cmd == CMD_CLEAR)
                        begin
                            addr_reg  <= '0;
                            state_reg <= ST_CLEAR;
                        end
                        else
                        begin
                            state_reg <= ST_BOX;
                        end
                    end
                end

                ST_BOX:
                begin
                    minx_reg <= bx_lo;
                    maxx_reg <= bx_hi;
                    miny_reg <= by_lo;
                    maxy_reg <= by_hi;
                    x_reg    <= bx_lo;
                    y_reg    <= by_lo;
                    mcnt_reg <= '0;
                    state_reg <= box_empty ? ST_IDLE : ST_MUL;
                end

                // One product per cycle; the next cycle folds it into its edge value or the address.
                ST_MUL:
                begin
                    prod_reg <= prod;
                    mcnt_reg <= mcnt_reg + 1'b1;
                    case (mcnt_reg)
                        3'd1:    e_reg[0] <= EW'(prod_reg);
                        3'd2:    e_reg[0] <= e_reg[0] - EW'(prod_reg);
                        3'd3:    e_reg[1] <= EW'(prod_reg);
                        3'd4:    e_reg[1] <= e_reg[1] - EW'(prod_reg);
                        3'd5:    e_reg[2] <= EW'(prod_reg);
                        3'd6:    e_reg[2] <= e_reg[2] - EW'(prod_reg);
                        3'd7:
                        begin
                            addr_reg  <= AW'(prod_reg) + AW'(x_reg);
                            state_reg <= ST_CHK;
                        end
                        default:
                        begin
                        end
                    endcase
                end

                // Coverage: all edges non-negative and a non-degenerate triangle.
                ST_CHK:
                begin
                    dop_reg <= DOP_L0;
                    if (any_neg || (s_sum == '0))
                    begin
                        state_reg <= ST_NEXT;
                    end
                    else
                    begin
                        state_reg <= ST_DIV_GO;
                    end
                end

                ST_DIV_GO:
                begin
                    if ((dop_reg == DOP_Z) && asum_zero)
                    begin
                        z_reg     <= DEPTH_MAX;
                        wt_reg[0] <= '0;
                        wt_reg[1] <= '0;
                        wt_reg[2] <= '0;
                        state_reg <= ST_MEM_RD;
                    end
                    else
                    begin
                        state_reg <= ST_DIV_WAIT;
                    end
                end

                ST_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        case (dop_reg)
                            DOP_L0: l_reg[0] <= div_rsp.quo[16:0];
                            DOP_L1: l_reg[1] <= div_rsp.quo[16:0];
                            DOP_L2: l_reg[2] <= div_rsp.quo[16:0];
                            DOP_A0: a_reg[0] <= div_rsp.quo[40:0];
                            DOP_A1: a_reg[1] <= div_rsp.quo[40:0];
                            DOP_A2: a_reg[2] <= div_rsp.quo[40:0];
                            DOP_Z:  z_reg <= (div_rsp.quo > DIV_NW'(DEPTH_MAX)) ?
                                             DEPTH_MAX : div_rsp.quo[23:0];
                            DOP_W0: wt_reg[0] <= div_rsp.quo[16:0];
                            DOP_W1: wt_reg[1] <= div_rsp.quo[16:0];
                            default: wt_reg[2] <= div_rsp.quo[16:0];
                        endcase
                        if (dop_reg == DOP_W2)
                        begin
                            state_reg <= ST_MEM_RD;
                        end
                        else
                        begin
                            dop_reg   <= dop_reg + 1'b1;
                            state_reg <= ST_DIV_GO;
                        end
                    end
                end

                ST_MEM_RD:
                begin
                    state_reg <= ST_MEM_CMP;
                end

                // Ties pass; the store write happens in this cycle too.
                ST_MEM_CMP:
                begin
                    state_reg <= depth_pass ? ST_EMIT : ST_NEXT;
                end

                // A new fragment pushes the held one out, which is then not the last.
                ST_EMIT:
                begin
                    if (!hold_vld_reg)
                    begin
                        hold_reg     <= frag;
                        hold_vld_reg <= 1'b1;
                        state_reg    <= ST_NEXT;
                    end
                    else if (out_free)
                    begin
                        out_reg     <= hold_reg;
                        hold_reg    <= frag;
                        state_reg   <= ST_NEXT;
                    end
                end

                ST_NEXT:
                begin
                    mcnt_reg <= '0;
                    if (x_reg == maxx_reg)
                    begin
                        x_reg <= minx_reg;
                        if (y_reg == maxy_reg)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                        else
                        begin
                            y_reg     <= y_reg + ONE_C;
                            state_reg <= ST_MUL;
                        end
                    end
                    else
                    begin
                        x_reg     <= x_reg + ONE_C;
                        state_reg <= ST_MUL;
                    end
                end

                ST_FLUSH:
                begin
                    if (!hold_vld_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_reg               <= last_frag;
                        hold_vld_reg          <= 1'b0;
                        state_reg             <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Every held fragment has left by the time the block takes a new item.
    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_vld_reg)
        else $error("fragment still held while idle");

    // The scan position never leaves the clipped box while edges are formed.
    a_scan_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (x_reg >= minx_reg) && (x_reg <= maxx_reg)
                                  && (y_reg >= miny_reg) && (y_reg <= maxy_reg))
        else $error("scan position outside the box");

    // Final weights are at most one before the depth test.
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MEM_RD) |-> (wt_reg[0] <= WEIGHT_ONE) && (wt_reg[1] <= WEIGHT_ONE)
                                     && (wt_reg[2] <= WEIGHT_ONE))
        else $error("weight above one");

endmodule
